[rtl/multi_servo_ramp_controller_defines.svh]
// Assertion macros of the servo ramp controller checker.
// No dependencies; included by the checker file.
`ifndef MULTI_SERVO_RAMP_CONTROLLER_DEFINES_SVH
`define MULTI_SERVO_RAMP_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MSRC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MSRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/msrc_pkg.sv]
// Shared constants, command codes and types of the servo ramp controller.
// No dependencies; used by msrc_tick_unit and the top level.
package msrc_pkg;

	localparam int NUM_SERVOS_DEFAULT = 16;
	localparam int MAX_RESULTS        = 32;
	localparam int POS_W              = 16;
	localparam int HOLD_W             = 17;
	localparam int SERVO_W            = 5;
	localparam int MODE_W             = 3;

	localparam logic [POS_W-1:0] NEUTRAL_POS      = 16'd1500;
	localparam logic [POS_W-1:0] FULL_SPEED_RESET = 16'hFFFF;
	localparam logic [POS_W-1:0] MAX_LIMIT_RESET  = 16'hFFFF;

	localparam logic [MODE_W-1:0] MODE_POS       = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SPD       = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SPD_POS   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_LIMITS    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_REL_TIME  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_TICK      = 3'd5;
	localparam logic [MODE_W-1:0] MODE_REL_ALL   = 3'd6;

	// State of one channel as seen by the tick step unit.
	typedef struct packed {
		logic [POS_W-1:0]  cur;
		logic [POS_W-1:0]  tgt;
		logic [POS_W-1:0]  spd;
		logic [POS_W-1:0]  rel_limit;
		logic              rel_on;
		logic [HOLD_W-1:0] hold;
		logic              running;
	} tick_chan_t;

	// Updated channel state and the results one tick step produces.
	typedef struct packed {
		logic              step_emit;
		logic [POS_W-1:0]  step_pos;
		logic              rel_emit;
		logic              clear_target;
		logic [HOLD_W-1:0] next_hold;
		logic              next_running;
	} tick_res_t;

endpackage

[rtl/msrc_tick_unit.sv]
// Shared step unit: moves one channel one ramp step and advances its release timer.
// Depends on msrc_pkg.
module msrc_tick_unit (
	input  msrc_pkg::tick_chan_t chan,
	output msrc_pkg::tick_res_t  res
);

	logic        active;
	logic        moving;
	logic        up;
	logic [16:0] sum;
	logic        wrapped;
	logic        past;
	logic        restart;
	logic        run1;
	logic [16:0] cnt1;
	logic [16:0] cnt2;
	logic        expire;

	assign active  = (chan.tgt != '0);
	assign moving  = active && (chan.cur != chan.tgt);
	assign up      = (chan.cur < chan.tgt);

	// One adder serves both directions: subtraction is cur + ~spd + 1.
	assign sum     = {1'b0, chan.cur} + {1'b0, (up ? chan.spd : ~chan.spd)} + 17'(!up);
	assign wrapped = up ? sum[16] : !sum[16];
	assign past    = up ? (sum[15:0] > chan.tgt) : (sum[15:0] < chan.tgt);

	assign restart = moving && chan.rel_on;
	assign run1    = restart || chan.running;
	assign cnt1    = restart ? '0 : chan.hold;
	assign cnt2    = cnt1 + 17'd1;
	assign expire  = active && run1 && (cnt2 > {1'b0, chan.rel_limit});

	always_comb begin
		res.step_emit    = moving;
		res.step_pos     = chan.cur;
		if (moving) begin
			res.step_pos = (wrapped || past) ? chan.tgt : sum[15:0];
		end
		res.rel_emit     = expire;
		res.clear_target = expire;
		res.next_hold    = chan.hold;
		res.next_running = chan.running;
		if (active) begin
			res.next_hold    = run1 ? cnt2 : cnt1;
			res.next_running = run1 && !expire;
		end
	end

endmodule

[rtl/multi_servo_ramp_controller.sv]
// Top level of the multi-channel servo position ramp controller.
// Depends on msrc_pkg and msrc_tick_unit.
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ----------------------------------------------
//  command   in_valid / in_ready    mode, servo_number, position_value, speed_value,
//                                   limit_low, limit_high, release_ticks,
//                                   release_disable
//  pulse     out_valid / out_ready  out_servo, pulse_value, last_flag
//  config    cfg_wr_en              cfg_wr_data (full speed code)
//
// A request is taken only in idle. Speed, limit and release-time requests pass
// execute and flush, position requests also apply, and release-all and ticks
// walk every channel: the shared step unit handles one channel per cycle unless
// the pulse side holds it; a channel that moves and expires also visits S_TICKREL.
// Reset puts every channel into its reset state at once; there is no clearing pass.
// A stalled pulse channel holds the sequencer only when a second result is waiting.
module multi_servo_ramp_controller #(
	parameter int NUM_SERVOS = msrc_pkg::NUM_SERVOS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [4:0]  servo_number,
	input  logic [15:0] position_value,
	input  logic [15:0] speed_value,
	input  logic [15:0] limit_low,
	input  logic [15:0] limit_high,
	input  logic [15:0] release_ticks,
	input  logic        release_disable,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  out_servo,
	output logic [15:0] pulse_value,
	output logic        last_flag
);

	localparam int CH_W  = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
	localparam int RES_W = $clog2(msrc_pkg::MAX_RESULTS + 1);

	// Sequencer states.
	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_EXEC    = 3'd1;
	localparam logic [2:0] S_APPLY   = 3'd2;
	localparam logic [2:0] S_TICK    = 3'd3;
	localparam logic [2:0] S_TICKREL = 3'd4;
	localparam logic [2:0] S_RELALL  = 3'd5;
	localparam logic [2:0] S_FLUSH   = 3'd6;

	// Per-channel state. Every entry is read only at the channel under work.
	logic [15:0] cur_q   [NUM_SERVOS];
	logic [15:0] tgt_q   [NUM_SERVOS];
	logic [15:0] spd_q   [NUM_SERVOS];
	logic [15:0] min_q   [NUM_SERVOS];
	logic [15:0] max_q   [NUM_SERVOS];
	logic [15:0] rlim_q  [NUM_SERVOS];
	logic        ron_q   [NUM_SERVOS];
	logic [16:0] hold_q  [NUM_SERVOS];
	logic        run_q   [NUM_SERVOS];

	logic [15:0]      fsc_q;
	logic [2:0]       state_q;
	logic [CH_W-1:0]  ch_q;
	logic             chv_q;
	logic [RES_W-1:0] res_cnt_q;

	// Request fields captured on acceptance, then the clamped position.
	logic [2:0]  mode_q;
	logic [15:0] pos_q;
	logic [15:0] spdin_q;
	logic [15:0] lo_q;
	logic [15:0] hi_q;
	logic [15:0] rt_q;
	logic        rdis_q;
	logic [15:0] clamp_q;
	logic        pos_zero_q;

	// One result waits in the pending register until the next one shows up or
	// the request ends, so that the last result can be flagged.
	logic        pend_valid_q;
	logic [4:0]  pend_servo_q;
	logic [15:0] pend_pulse_q;

	logic        out_valid_q;
	logic [4:0]  out_servo_q;
	logic [15:0] out_pulse_q;
	logic        out_last_q;

	logic             chan_ok;
	logic [4:0]       num_m1;
	logic             last_ch;
	logic             out_free;
	logic             go;
	logic             push;
	logic [15:0]      push_pulse;
	logic             push_take;
	logic             move_push;
	logic             move_flush;
	logic             apply_jump;
	logic             at_max;

	msrc_pkg::tick_chan_t tick_in;
	msrc_pkg::tick_res_t  tick_out;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign out_servo   = out_servo_q;
	assign pulse_value = out_pulse_q;
	assign last_flag   = out_last_q;

	assign chan_ok  = (servo_number != 5'd0) && ({1'b0, servo_number} <= 6'(NUM_SERVOS));
	assign num_m1   = servo_number - 5'd1;
	assign last_ch  = (ch_q == CH_W'(NUM_SERVOS - 1));
	assign out_free = !out_valid_q || out_ready;
	// The sequencer may produce a result only when the pending one can move on.
	assign go       = !pend_valid_q || out_free;
	assign at_max   = (res_cnt_q >= RES_W'(msrc_pkg::MAX_RESULTS));

	assign tick_in.cur       = cur_q[ch_q];
	assign tick_in.tgt       = tgt_q[ch_q];
	assign tick_in.spd       = spd_q[ch_q];
	assign tick_in.rel_limit = rlim_q[ch_q];
	assign tick_in.rel_on    = ron_q[ch_q];
	assign tick_in.hold      = hold_q[ch_q];
	assign tick_in.running   = run_q[ch_q];

	msrc_tick_unit u_tick (
		.chan (tick_in),
		.res  (tick_out)
	);

	// A position jumps when the channel runs at full speed or is already there.
	assign apply_jump = (spd_q[ch_q] == fsc_q) || (cur_q[ch_q] == clamp_q);

	always_comb begin
		push       = 1'b0;
		push_pulse = '0;
		case (state_q)
			S_APPLY: begin
				push       = pos_zero_q || apply_jump;
				push_pulse = clamp_q;
			end
			S_TICK: begin
				push       = tick_out.step_emit || tick_out.rel_emit;
				push_pulse = tick_out.step_emit ? tick_out.step_pos : '0;
			end
			S_TICKREL: begin
				push = 1'b1;
			end
			S_RELALL: begin
				push = 1'b1;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// Results past the per-request limit are dropped.
	assign push_take  = go && push && !at_max;
	assign move_push  = push_take && pend_valid_q;
	assign move_flush = (state_q == S_FLUSH) && pend_valid_q && out_free;

	// Control state and channel state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsc_q        <= msrc_pkg::FULL_SPEED_RESET;
			state_q      <= S_IDLE;
			ch_q         <= '0;
			chv_q        <= 1'b0;
			res_cnt_q    <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < NUM_SERVOS; i++) begin
				cur_q[i]  <= msrc_pkg::NEUTRAL_POS;
				tgt_q[i]  <= '0;
				spd_q[i]  <= msrc_pkg::FULL_SPEED_RESET;
				min_q[i]  <= '0;
				max_q[i]  <= msrc_pkg::MAX_LIMIT_RESET;
				rlim_q[i] <= '0;
				ron_q[i]  <= 1'b0;
				hold_q[i] <= '0;
				run_q[i]  <= 1'b0;
			end
		end else begin
			if (cfg_wr_en) begin
				fsc_q <= cfg_wr_data;
			end

			if (move_push || move_flush) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (push_take) begin
				pend_valid_q <= 1'b1;
				res_cnt_q    <= res_cnt_q + RES_W'(1);
			end else if (move_flush) begin
				pend_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q   <= S_EXEC;
						res_cnt_q <= '0;
						chv_q     <= chan_ok;
						if (mode == msrc_pkg::MODE_TICK || mode == msrc_pkg::MODE_REL_ALL) begin
							ch_q <= '0;
						end else begin
							ch_q <= num_m1[CH_W-1:0];
						end
					end
				end
				S_EXEC: begin
					case (mode_q)
						msrc_pkg::MODE_POS: begin
							if (chv_q) begin
								state_q <= S_APPLY;
							end else begin
								state_q <= S_FLUSH;
							end
						end
						msrc_pkg::MODE_SPD_POS: begin
							if (chv_q) begin
								spd_q[ch_q] <= spdin_q;
								state_q     <= S_APPLY;
							end else begin
								state_q <= S_FLUSH;
							end
						end
						msrc_pkg::MODE_SPD: begin
							state_q <= S_FLUSH;
							if (chv_q) begin
								spd_q[ch_q] <= spdin_q;
							end
						end
						msrc_pkg::MODE_LIMITS: begin
							state_q <= S_FLUSH;
							if (chv_q) begin
								min_q[ch_q] <= lo_q;
								max_q[ch_q] <= hi_q;
							end
						end
						msrc_pkg::MODE_REL_TIME: begin
							state_q <= S_FLUSH;
							if (chv_q) begin
								if (rdis_q) begin
									ron_q[ch_q] <= 1'b0;
									run_q[ch_q] <= 1'b0;
								end else begin
									rlim_q[ch_q] <= rt_q;
									ron_q[ch_q]  <= 1'b1;
									hold_q[ch_q] <= '0;
									run_q[ch_q]  <= 1'b1;
								end
							end
						end
						msrc_pkg::MODE_TICK: begin
							state_q <= S_TICK;
						end
						msrc_pkg::MODE_REL_ALL: begin
							state_q <= S_RELALL;
						end
						default: begin
							state_q <= S_FLUSH;
						end
					endcase
				end
				S_APPLY: begin
					if (go) begin
						if (!pos_zero_q && apply_jump) begin
							cur_q[ch_q] <= clamp_q;
						end
						tgt_q[ch_q] <= clamp_q;
						if (ron_q[ch_q]) begin
							hold_q[ch_q] <= '0;
							run_q[ch_q]  <= 1'b1;
						end
						state_q <= S_FLUSH;
					end
				end
				S_TICK: begin
					if (go) begin
						cur_q[ch_q]  <= tick_out.step_pos;
						hold_q[ch_q] <= tick_out.next_hold;
						run_q[ch_q]  <= tick_out.next_running;
						if (tick_out.clear_target) begin
							tgt_q[ch_q] <= '0;
						end
						if (tick_out.step_emit && tick_out.rel_emit) begin
							state_q <= S_TICKREL;
						end else if (last_ch) begin
							state_q <= S_FLUSH;
						end else begin
							ch_q <= ch_q + CH_W'(1);
						end
					end
				end
				S_TICKREL: begin
					if (go) begin
						if (last_ch) begin
							state_q <= S_FLUSH;
						end else begin
							ch_q    <= ch_q + CH_W'(1);
							state_q <= S_TICK;
						end
					end
				end
				S_RELALL: begin
					if (go) begin
						tgt_q[ch_q] <= '0;
						if (ron_q[ch_q]) begin
							hold_q[ch_q] <= '0;
							run_q[ch_q]  <= 1'b1;
						end
						if (last_ch) begin
							state_q <= S_FLUSH;
						end else begin
							ch_q <= ch_q + CH_W'(1);
						end
					end
				end
				S_FLUSH: begin
					if (!pend_valid_q || out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: request fields, clamped position and result data.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			mode_q     <= mode;
			pos_q      <= position_value;
			spdin_q    <= speed_value;
			lo_q       <= limit_low;
			hi_q       <= limit_high;
			rt_q       <= release_ticks;
			rdis_q     <= release_disable;
		end
		// Clamp to the limits; a zero request stays zero.
		if (state_q == S_EXEC) begin
			pos_zero_q <= (pos_q == '0);
			if (pos_q == '0) begin
				clamp_q <= '0;
			end else if (pos_q < min_q[ch_q]) begin
				clamp_q <= min_q[ch_q];
			end else if (pos_q > max_q[ch_q]) begin
				clamp_q <= max_q[ch_q];
			end else begin
				clamp_q <= pos_q;
			end
		end
		if (push_take) begin
			pend_servo_q <= 5'(ch_q) + 5'd1;
			pend_pulse_q <= push_pulse;
		end
		if (move_push || move_flush) begin
			out_servo_q <= pend_servo_q;
			out_pulse_q <= pend_pulse_q;
			out_last_q  <= move_flush;
		end
	end

endmodule

[rtl/msrc_checker.sv]
// Port-level checker for the servo ramp controller, bound to the top level.
// Depends on multi_servo_ramp_controller_defines.svh and msrc_pkg.
`include "multi_servo_ramp_controller_defines.svh"

module msrc_checker #(
	parameter int NUM_SERVOS = msrc_pkg::NUM_SERVOS_DEFAULT
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [4:0]  out_servo,
	input logic [15:0] pulse_value,
	input logic        last_flag
);

	// A result that is not the last one means the request is still running.
	`MSRC_ASSERT_SAME(a_busy_mid_request, out_valid && !last_flag, !in_ready, "ready during request")

	// Every result names an existing channel.
	`MSRC_ASSERT_SAME(a_servo_range, out_valid, (out_servo != 5'd0) && (32'(out_servo) <= NUM_SERVOS), "bad channel in result")

	// An accepted request always leaves the block busy in the following cycle.
	`MSRC_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "ready right after accept")

	// A stalled result holds its payload.
	`MSRC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_servo) && $stable(pulse_value) && $stable(last_flag), "stalled result changed")

endmodule

bind multi_servo_ramp_controller msrc_checker #(
	.NUM_SERVOS (NUM_SERVOS)
) u_msrc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.out_servo   (out_servo),
	.pulse_value (pulse_value),
	.last_flag   (last_flag)
);

[dv/multi_servo_ramp_controller_checker.sv]
// Checker for the servo ramp controller: predicts pulse results and compares them.
// Depends on msrc_pkg; instantiated by multi_servo_ramp_controller_test beside the block.
module multi_servo_ramp_controller_checker #(
	parameter int NUM_CH = msrc_pkg::NUM_SERVOS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [4:0]  servo_number,
	input  logic [15:0] position_value,
	input  logic [15:0] speed_value,
	input  logic [15:0] limit_low,
	input  logic [15:0] limit_high,
	input  logic [15:0] release_ticks,
	input  logic        release_disable,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [4:0]  out_servo,
	input  logic [15:0] pulse_value,
	input  logic        last_flag,
	output int          error_count,
	output int          pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [4:0]  servo;
		logic [15:0] pulse;
		logic        is_last;
	} pulse_t;

	// Per-channel copy of the controller state.
	logic [15:0] jump_code;
	logic [15:0] cur_pos  [NUM_CH];
	logic [15:0] tgt_pos  [NUM_CH];
	logic [15:0] step_spd [NUM_CH];
	logic [15:0] min_lim  [NUM_CH];
	logic [15:0] max_lim  [NUM_CH];
	logic [15:0] rel_lim  [NUM_CH];
	logic        rel_on   [NUM_CH];
	logic [16:0] hold_cnt [NUM_CH];
	logic        hold_run [NUM_CH];

	pulse_t pulse_expect[$];
	pulse_t step_pulses[msrc_pkg::MAX_RESULTS];
	int     n_step_pulses;
	pulse_t seen, want;

	initial begin
		error_count = 0;
		pending_count = 0;
	end

	function automatic void reset_channels();
		jump_code = msrc_pkg::FULL_SPEED_RESET;
		for (int i = 0; i < NUM_CH; i++) begin
			cur_pos[i]  = msrc_pkg::NEUTRAL_POS;
			tgt_pos[i]  = '0;
			step_spd[i] = msrc_pkg::FULL_SPEED_RESET;
			min_lim[i]  = '0;
			max_lim[i]  = msrc_pkg::MAX_LIMIT_RESET;
			rel_lim[i]  = '0;
			rel_on[i]   = 1'b0;
			hold_cnt[i] = '0;
			hold_run[i] = 1'b0;
		end
	endfunction

	function automatic void add_pulse(int ch, logic [15:0] value);
		if (n_step_pulses < msrc_pkg::MAX_RESULTS) begin
			step_pulses[n_step_pulses] = '{servo: 5'(ch + 1), pulse: value, is_last: 1'b0};
			n_step_pulses++;
		end
	endfunction

	function automatic void restart_hold(int ch);
		if (rel_on[ch]) begin
			hold_cnt[ch] = '0;
			hold_run[ch] = 1'b1;
		end
	endfunction

	function automatic void move_to(int ch, logic [15:0] req);
		logic [15:0] p;
		p = req;
		if (p == '0) begin
			add_pulse(ch, '0);
		end else begin
			if (p < min_lim[ch])
				p = min_lim[ch];
			else if (p > max_lim[ch])
				p = max_lim[ch];
			if (step_spd[ch] == jump_code || cur_pos[ch] == p) begin
				add_pulse(ch, p);
				cur_pos[ch] = p;
			end
		end
		tgt_pos[ch] = p;
		restart_hold(ch);
	endfunction

	// One tick walks the channels in order; a moving channel reports its new
	// position, and an expired hold timer releases the channel afterwards.
	function automatic void step_all();
		logic [15:0] nxt;
		for (int i = 0; i < NUM_CH; i++) begin
			if (tgt_pos[i] != '0) begin
				if (cur_pos[i] != tgt_pos[i]) begin
					if (cur_pos[i] < tgt_pos[i]) begin
						nxt = cur_pos[i] + step_spd[i];
						if (nxt > tgt_pos[i] || nxt < cur_pos[i])
							nxt = tgt_pos[i];
					end else begin
						nxt = cur_pos[i] - step_spd[i];
						if (nxt < tgt_pos[i] || nxt > cur_pos[i])
							nxt = tgt_pos[i];
					end
					cur_pos[i] = nxt;
					add_pulse(i, nxt);
					restart_hold(i);
				end
				if (hold_run[i]) begin
					hold_cnt[i] = hold_cnt[i] + 17'd1;
					if (hold_cnt[i] > {1'b0, rel_lim[i]}) begin
						hold_run[i] = 1'b0;
						tgt_pos[i] = '0;
						add_pulse(i, '0);
					end
				end
			end
		end
	endfunction

	function automatic void apply_command();
		logic ok;
		int   ch;
		ok = servo_number >= 5'd1 && int'(servo_number) <= NUM_CH;
		ch = ok ? int'(servo_number) - 1 : 0;
		n_step_pulses = 0;
		case (mode)
			msrc_pkg::MODE_POS: begin
				if (ok)
					move_to(ch, position_value);
			end
			msrc_pkg::MODE_SPD: begin
				if (ok)
					step_spd[ch] = speed_value;
			end
			msrc_pkg::MODE_SPD_POS: begin
				if (ok) begin
					step_spd[ch] = speed_value;
					move_to(ch, position_value);
				end
			end
			msrc_pkg::MODE_LIMITS: begin
				if (ok) begin
					min_lim[ch] = limit_low;
					max_lim[ch] = limit_high;
				end
			end
			msrc_pkg::MODE_REL_TIME: begin
				if (ok) begin
					if (release_disable) begin
						rel_on[ch] = 1'b0;
						hold_run[ch] = 1'b0;
					end else begin
						rel_lim[ch] = release_ticks;
						rel_on[ch] = 1'b1;
						hold_cnt[ch] = '0;
						hold_run[ch] = 1'b1;
					end
				end
			end
			msrc_pkg::MODE_TICK: step_all();
			msrc_pkg::MODE_REL_ALL: begin
				for (int i = 0; i < NUM_CH; i++)
					move_to(i, '0);
			end
			default: ;
		endcase
		if (n_step_pulses > 0)
			step_pulses[n_step_pulses - 1].is_last = 1'b1;
		for (int k = 0; k < n_step_pulses; k++)
			pulse_expect.push_back(step_pulses[k]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_channels();
			pulse_expect.delete();
		end else begin
			if (out_valid && out_ready) begin
				seen = '{servo: out_servo, pulse: pulse_value, is_last: last_flag};
				if (pulse_expect.size() == 0) begin
					if (error_count < 10)
						$display("%0t: unexpected pulse servo %0d value %0d last %0b",
							$realtime, seen.servo, seen.pulse, seen.is_last);
					error_count++;
				end else begin
					want = pulse_expect.pop_front();
					if (seen.servo !== want.servo || seen.pulse !== want.pulse ||
							seen.is_last !== want.is_last) begin
						if (error_count < 10)
							$display("%0t: expected %0d/%0d/%0b, got %0d/%0d/%0b",
								$realtime, want.servo, want.pulse, want.is_last,
								seen.servo, seen.pulse, seen.is_last);
						error_count++;
					end
				end
			end
			if (cfg_wr_en)
				jump_code = cfg_wr_data;
			if (in_valid && in_ready)
				apply_command();
		end
		pending_count = pulse_expect.size();
	end

endmodule

[dv/multi_servo_ramp_controller_test.sv]
// Top of the servo ramp controller testbench: clock, reset, requests and verdict.
// Depends on msrc_pkg, multi_servo_ramp_controller and multi_servo_ramp_controller_checker.
module multi_servo_ramp_controller_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_CH = msrc_pkg::NUM_SERVOS_DEFAULT;
	localparam logic [2:0] MODE_UNUSED = 3'd7;
	// A tick can visit the tick-release state at every channel; leave some margin
	// before touching the register after the last pulse has come out.
	localparam int DRAIN_CYCLES = 2 * NUM_CH + 10;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASE_ITEMS = 90;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  mode = '0;
	logic [4:0]  servo_number = '0;
	logic [15:0] position_value = '0;
	logic [15:0] speed_value = '0;
	logic [15:0] limit_low = '0;
	logic [15:0] limit_high = '0;
	logic [15:0] release_ticks = '0;
	logic        release_disable = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [4:0]  out_servo;
	logic [15:0] pulse_value;
	logic        last_flag;
	int          error_count;
	int          pending_count;

	// Idle percentages of the request side and the pulse side.
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          cycle_count = 0;
	logic [15:0] jump_setting = msrc_pkg::FULL_SPEED_RESET;

	multi_servo_ramp_controller #(.NUM_SERVOS(NUM_CH)) uut (.*);

	multi_servo_ramp_controller_checker #(.NUM_CH(NUM_CH)) checker_i (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The pulse side stalls at random; one decision per falling edge.
	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Presents one request and returns on the falling edge after it is taken.
	// Valid is left high so that a back-to-back request needs no second update;
	// the next call either drops it while idling or replaces the payload.
	task automatic send_request(input logic [2:0] op, input logic [4:0] num,
			input logic [15:0] pos, input logic [15:0] spd, input logic [15:0] lo,
			input logic [15:0] hi, input logic [15:0] rt, input logic rdis);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid        <= 1'b1;
		mode            <= op;
		servo_number    <= num;
		position_value  <= pos;
		speed_value     <= spd;
		limit_low       <= lo;
		limit_high      <= hi;
		release_ticks   <= rt;
		release_disable <= rdis;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Holds off new requests until every predicted pulse has been seen, then
	// gives a request that produces no pulse time to finish.
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_jump_code(input logic [15:0] value);
		cfg_wr_en    <= 1'b1;
		cfg_wr_data  <= value;
		jump_setting = value;
		@(negedge clk);
		cfg_wr_en    <= 1'b0;
	endtask

	// Positions lean toward the usual servo range, with release, the extremes
	// and fully random words mixed in.
	function automatic logic [15:0] rand_position();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 16'($urandom);
			2: return $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
			default: return 16'($urandom_range(500, 2500));
		endcase
	endfunction

	// Speeds: mostly small ramps, sometimes zero, the current jump code or random.
	function automatic logic [15:0] rand_speed();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return jump_setting;
			2: return 16'($urandom);
			default: return 16'($urandom_range(1, 300));
		endcase
	endfunction

	// Random traffic. Ticks and position changes dominate so that channels
	// actually ramp and time out; a small share goes to bad channel numbers and
	// the unused mode, which the block ignores and which do not count here.
	task automatic run_random(input int n_items);
		int          counted;
		int          pick;
		logic [2:0]  op;
		logic [4:0]  num;
		logic [15:0] lo, hi, rt;
		logic        rdis;
		counted = 0;
		while (counted < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 28)
				op = msrc_pkg::MODE_TICK;
			else if (pick < 48)
				op = msrc_pkg::MODE_POS;
			else if (pick < 58)
				op = msrc_pkg::MODE_SPD;
			else if (pick < 70)
				op = msrc_pkg::MODE_SPD_POS;
			else if (pick < 80)
				op = msrc_pkg::MODE_LIMITS;
			else if (pick < 92)
				op = msrc_pkg::MODE_REL_TIME;
			else if (pick < 96)
				op = msrc_pkg::MODE_REL_ALL;
			else
				op = MODE_UNUSED;
			num = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, NUM_CH));
			case ($urandom_range(0, 3))
				0: begin
					lo = 16'($urandom);
					hi = 16'($urandom);
				end
				1: begin
					lo = '0;
					hi = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'hFFFF;
				end
				default: begin
					lo = 16'($urandom_range(300, 1200));
					hi = 16'($urandom_range(1800, 2700));
				end
			endcase
			rt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
			rdis = ($urandom_range(0, 3) == 0);
			send_request(op, num, rand_position(), rand_speed(), lo, hi, rt, rdis);
			if (op != MODE_UNUSED &&
					(op > msrc_pkg::MODE_REL_TIME || (num >= 5'd1 && num <= NUM_CH)))
				counted++;
		end
	endtask

	initial begin
		repeat (3)
			@(negedge clk);
		arst_n <= 1'b1;
		write_jump_code(16'hFFFF);

		// Directed part, at full-speed jump code 0xFFFF.
		// A tick with every channel released produces nothing.
		send_request(msrc_pkg::MODE_TICK, 5'd0, '0, '0, '0, '0, '0, 1'b0);
		// Channel 1 jumps to 2000, then ramps toward 2450 at 100 per tick
		// with a short release time.
		send_request(msrc_pkg::MODE_POS, 5'd1, 16'd2000, '0, '0, '0, '0, 1'b0);
		send_request(msrc_pkg::MODE_SPD, 5'd1, '0, 16'd100, '0, '0, '0, 1'b0);
		send_request(msrc_pkg::MODE_POS, 5'd1, 16'd2450, '0, '0, '0, '0, 1'b0);
		send_request(msrc_pkg::MODE_REL_TIME, 5'd1, '0, '0, '0, '0, 16'd3, 1'b0);
		// Channel 2 jumps to the top, then walks down by half the range.
		send_request(msrc_pkg::MODE_SPD_POS, 5'd2, 16'hFFFF, 16'hFFFF, '0, '0, '0, 1'b0);
		send_request(msrc_pkg::MODE_SPD_POS, 5'd2, 16'd1, 16'h8000, '0, '0, '0, 1'b0);
		// Clamping below and above the limits of channel 3.
		send_request(msrc_pkg::MODE_LIMITS, 5'd3, '0, '0, 16'd1000, 16'd3000, '0, 1'b0);
		send_request(msrc_pkg::MODE_POS, 5'd3, 16'd500, '0, '0, '0, '0, 1'b0);
		send_request(msrc_pkg::MODE_POS, 5'd3, 16'hFFFF, '0, '0, '0, '0, 1'b0);
		// A zero upper limit clamps every position to zero.
		send_request(msrc_pkg::MODE_LIMITS, 5'd4, '0, '0, 16'd0, 16'd0, '0, 1'b0);
		send_request(msrc_pkg::MODE_POS, 5'd4, 16'd1234, '0, '0, '0, '0, 1'b0);
		// Zero speed: the channel never moves but reports every tick.
		send_request(msrc_pkg::MODE_SPD_POS, 5'd5, 16'd3000, 16'd0, '0, '0, '0, 1'b0);
		// A ramped channel commanded to its present position reports at once.
		send_request(msrc_pkg::MODE_SPD, 5'd6, '0, 16'd10, '0, '0, '0, 1'b0);
		send_request(msrc_pkg::MODE_POS, 5'd6, 16'd1500, '0, '0, '0, '0, 1'b0);
		// A step that wraps past 16 bits saturates to the target.
		send_request(msrc_pkg::MODE_SPD_POS, 5'd8, 16'hFFFF, 16'hFFF0, '0, '0, '0, 1'b0);
		// Release timer set to the maximum, then switched off; the last
		// channel gets a zero release time.
		send_request(msrc_pkg::MODE_REL_TIME, 5'd7, '0, '0, '0, '0, 16'hFFFF, 1'b0);
		send_request(msrc_pkg::MODE_REL_TIME, 5'd7, '0, '0, '0, '0, '0, 1'b1);
		send_request(msrc_pkg::MODE_REL_TIME, 5'd16, '0, '0, '0, '0, 16'd0, 1'b0);
		send_request(msrc_pkg::MODE_POS, 5'd16, 16'd900, '0, '0, '0, '0, 1'b0);
		// Bad channel numbers and the unused mode are ignored.
		send_request(msrc_pkg::MODE_POS, 5'd0, 16'd700, '0, '0, '0, '0, 1'b0);
		send_request(msrc_pkg::MODE_POS, 5'd17, 16'd700, '0, '0, '0, '0, 1'b0);
		send_request(msrc_pkg::MODE_SPD_POS, 5'd31, 16'd700, 16'd5, '0, '0, '0, 1'b0);
		send_request(MODE_UNUSED, 5'd1, 16'd700, '0, '0, '0, '0, 1'b0);
		repeat (5)
			send_request(msrc_pkg::MODE_TICK, 5'd0, '0, '0, '0, '0, '0, 1'b0);
		send_request(msrc_pkg::MODE_POS, 5'd1, 16'd0, '0, '0, '0, '0, 1'b0);
		send_request(msrc_pkg::MODE_REL_ALL, 5'd0, '0, '0, '0, '0, '0, 1'b0);
		wait_quiet();

		// Jump code 0: zero speed now means an immediate jump. The request
		// side idles lightly while the pulse side stalls often.
		write_jump_code(16'h0000);
		send_idle_pct = 31;
		recv_idle_pct = 69;
		run_random(PHASE_ITEMS);
		wait_quiet();

		// A random jump code from 1 to 300, with the idling turned around.
		write_jump_code(16'($urandom_range(1, 300)));
		send_idle_pct = 69;
		recv_idle_pct = 31;
		run_random(PHASE_ITEMS);
		wait_quiet();

		// Back to the reset code, both sides at full rate.
		write_jump_code(16'hFFFF);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(PHASE_ITEMS);
		wait_quiet();

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
